/* sv/tbp_pkg.sv */
package tbp_pkg;

  // Default sizes of the prediction tables.
  localparam int LOCAL_TABLE_ENTRIES_DEF  = 256;
  localparam int GLOBAL_TABLE_ENTRIES_DEF = 1024;
  localparam int BTB_ENTRIES_DEF          = 256;
  localparam int LOCAL_HISTORY_BITS_DEF   = 10;
  localparam int GLOBAL_HISTORY_BITS_DEF  = 10;
  localparam int RETURN_STACK_DEPTH_DEF   = 16;

  // Fixed field widths.
  localparam int ADDR_W  = 32;
  localparam int GHR_W   = 10;
  localparam int DEPTH_W = 8;
  localparam int KIND_W  = 3;

  // Bit positions inside a BTB kind field.
  localparam int KIND_UNCOND_BIT = 0;
  localparam int KIND_CALL_BIT   = 1;
  localparam int KIND_RET_BIT    = 2;

  typedef enum logic [1:0] {
    OP_FETCH   = 2'd0,
    OP_BRANCH  = 2'd1,
    OP_JUMP    = 2'd2,
    OP_RESTORE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOCAL,
    ST_EXEC
  } state_t;

endpackage

/* sv/tournament_branch_predictor.sv */
// Channel  | Handshake          | Payload
// ---------+--------------------+------------------------------------------------
// input    | in_valid/in_ready  | op, pc, taken, target, ghr, jump_is_call,
//          |                    | jump_is_ret, ras_depth
// output   | out_valid/out_ready| pred_taken, predicted_pc, btb_hit, unconditional,
//          |                    | hit_is_call, hit_is_ret
//
// Each transaction passes through these steps after acceptance: one to issue the
// table reads, one for the dependent local counter read, one to decide and write
// back. The next transaction is accepted only after the write-back step is done.
// After reset a clearing pass zeroes the history, counter and chooser tables and
// the BTB valid bits, one entry per cycle, over as many entries as the deepest
// table has (1024 with the default sizes).
// A result still waiting on the output holds the next transaction in its
// write-back step.
module tournament_branch_predictor #(
  parameter int LOCAL_TABLE_ENTRIES  = tbp_pkg::LOCAL_TABLE_ENTRIES_DEF,
  parameter int GLOBAL_TABLE_ENTRIES = tbp_pkg::GLOBAL_TABLE_ENTRIES_DEF,
  parameter int BTB_ENTRIES          = tbp_pkg::BTB_ENTRIES_DEF,
  parameter int LOCAL_HISTORY_BITS   = tbp_pkg::LOCAL_HISTORY_BITS_DEF,
  parameter int GLOBAL_HISTORY_BITS  = tbp_pkg::GLOBAL_HISTORY_BITS_DEF,
  parameter int RETURN_STACK_DEPTH   = tbp_pkg::RETURN_STACK_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   op,
  input  logic [tbp_pkg::ADDR_W-1:0]   pc,
  input  logic                         taken,
  input  logic [tbp_pkg::ADDR_W-1:0]   target,
  input  logic [tbp_pkg::GHR_W-1:0]    ghr,
  input  logic                         jump_is_call,
  input  logic                         jump_is_ret,
  input  logic [tbp_pkg::DEPTH_W-1:0]  ras_depth,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         pred_taken,
  output logic [tbp_pkg::ADDR_W-1:0]   predicted_pc,
  output logic                         btb_hit,
  output logic                         unconditional,
  output logic                         hit_is_call,
  output logic                         hit_is_ret
);
  import tbp_pkg::*;

  localparam int LI_W   = $clog2(LOCAL_TABLE_ENTRIES);
  localparam int GI_W   = $clog2(GLOBAL_TABLE_ENTRIES);
  localparam int BI_W   = $clog2(BTB_ENTRIES);
  localparam int LHB    = LOCAL_HISTORY_BITS;
  localparam int GHB    = GLOBAL_HISTORY_BITS;
  localparam int LCTR_N = 1 << LHB;
  localparam int RS_W   = $clog2(RETURN_STACK_DEPTH);
  localparam int MAX_A  = (LOCAL_TABLE_ENTRIES > LCTR_N) ? LOCAL_TABLE_ENTRIES : LCTR_N;
  localparam int MAX_B  = (GLOBAL_TABLE_ENTRIES > BTB_ENTRIES) ?
                          GLOBAL_TABLE_ENTRIES : BTB_ENTRIES;
  localparam int CLR_N  = (MAX_A > MAX_B) ? MAX_A : MAX_B;
  localparam int CLR_W  = $clog2(CLR_N);

  // Table memories.
  logic [LHB-1:0]    lht_mem  [LOCAL_TABLE_ENTRIES];
  logic [1:0]        lctr_mem [LCTR_N];
  logic [1:0]        gctr_mem [GLOBAL_TABLE_ENTRIES];
  logic [1:0]        chs_mem  [GLOBAL_TABLE_ENTRIES];
  logic              bval_mem [BTB_ENTRIES];
  logic [ADDR_W-1:0] btag_mem [BTB_ENTRIES];
  logic [ADDR_W-1:0] btgt_mem [BTB_ENTRIES];
  logic [KIND_W-1:0] bkind_mem[BTB_ENTRIES];

  // Return stack registers, read at the top slot only.
  logic [ADDR_W-1:0]  ras_addr[RETURN_STACK_DEPTH];
  logic [DEPTH_W-1:0] ras_rep [RETURN_STACK_DEPTH];

  state_t state, state_next;
  logic [CLR_W-1:0]   clr;
  logic [GHB-1:0]     ghist;
  logic [DEPTH_W-1:0] rtop;

  // Registered transaction.
  op_t               r_op;
  logic [ADDR_W-1:0] r_pc, r_target;
  logic              r_taken, r_call, r_ret;
  logic [GHR_W-1:0]  r_ghr;
  logic [DEPTH_W-1:0] r_depth;

  // Read data.
  logic [LHB-1:0]    lht_q;
  logic [1:0]        lctr_q, gctr_q, chs_q;
  logic              bval_q;
  logic [ADDR_W-1:0] btag_q, btgt_q;
  logic [KIND_W-1:0] bkind_q;

  logic accept, out_free, exec_go, clr_done;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign exec_go  = (state == ST_EXEC) && out_free;
  assign clr_done = (clr == CLR_W'(CLR_N - 1));
  assign in_ready = (state == ST_IDLE);

  // Table indices of the held transaction.
  logic [ADDR_W-1:0] word, gx;
  logic [LI_W-1:0]   li;
  logic [GI_W-1:0]   gi;
  logic [BI_W-1:0]   bi;
  always_comb begin
    word = {2'b00, r_pc[ADDR_W-1:2]};
    if (r_op == OP_FETCH) begin
      gx = word ^ ADDR_W'(ghist);
    end else begin
      gx = word ^ ADDR_W'(r_ghr);
    end
    li = word[LI_W-1:0];
    gi = gx[GI_W-1:0];
    bi = word[BI_W-1:0];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_done) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_READ;
      ST_READ:  state_next = ST_LOCAL;
      ST_LOCAL: state_next = ST_EXEC;
      ST_EXEC:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr <= clr + 1'b1;
    end
  end

  // Capture the accepted transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      r_op     <= op_t'(op);
      r_pc     <= pc;
      r_taken  <= taken;
      r_target <= target;
      r_ghr    <= ghr;
      r_call   <= jump_is_call;
      r_ret    <= jump_is_ret;
      r_depth  <= ras_depth;
    end
  end

  // Decision logic of the write-back step.
  logic              hit, unc, is_call, is_ret, ptaken, rtop_nz;
  logic [KIND_W-1:0] kind;
  logic [ADDR_W-1:0] pc4, next_pc, top_addr;
  logic [DEPTH_W-1:0] top_rep, rtop_m1;
  logic [RS_W-1:0]   tslot, pslot;
  logic              l_ok, g_ok, hbit;
  logic [1:0]        lctr_new, gctr_new, chs_new;
  logic [LHB:0]      lh_shift;
  logic [GHB:0]      gh_shift;

  function automatic logic [1:0] sat_step(input logic [1:0] c, input logic up);
    logic [1:0] r;
    r = c;
    if (up) begin
      if (c != 2'd3) r = c + 2'd1;
    end else begin
      if (c != 2'd0) r = c - 2'd1;
    end
    return r;
  endfunction

  always_comb begin
    hit      = bval_q && (btag_q == r_pc);
    kind     = hit ? bkind_q : '0;
    unc      = kind[KIND_UNCOND_BIT];
    is_call  = kind[KIND_CALL_BIT];
    is_ret   = kind[KIND_RET_BIT];
    rtop_nz  = (rtop != '0);
    rtop_m1  = rtop - 1'b1;
    tslot    = rtop_m1[RS_W-1:0];
    pslot    = rtop[RS_W-1:0];
    top_addr = ras_addr[tslot];
    top_rep  = ras_rep[tslot];
    pc4      = r_pc + ADDR_W'(4);

    priority if (unc) begin
      ptaken = 1'b1;
    end else if (!hit) begin
      ptaken = 1'b0;
    end else if (chs_q[1]) begin
      ptaken = gctr_q[1];
    end else begin
      ptaken = lctr_q[1];
    end

    next_pc = pc4;
    if (ptaken) begin
      if (is_ret && rtop_nz) next_pc = top_addr;
      else next_pc = btgt_q;
    end

    hbit     = (is_ret || is_call || unc) ? 1'b1 : ptaken;
    gh_shift = {ghist, hbit};

    // Training values.
    l_ok     = (lctr_q[1] == r_taken);
    g_ok     = (gctr_q[1] == r_taken);
    lctr_new = sat_step(lctr_q, r_taken);
    gctr_new = sat_step(gctr_q, r_taken);
    chs_new  = chs_q;
    if (g_ok && !l_ok) chs_new = sat_step(chs_q, 1'b1);
    else if (l_ok && !g_ok) chs_new = sat_step(chs_q, 1'b0);
    lh_shift = {lht_q, r_taken};
  end

  // Memory write controls; the clearing pass shares the write ports.
  logic clearing, wr_train, wr_btb;
  logic [LI_W-1:0]  lht_wa;
  logic [LHB-1:0]   lht_wd, lctr_wa;
  logic [1:0]       lctr_wd, gctr_wd, chs_wd;
  logic [GI_W-1:0]  g_wa;
  logic [BI_W-1:0]  b_wa;
  logic             bval_wd;
  logic [KIND_W-1:0] bkind_wd;
  always_comb begin
    clearing = (state == ST_CLEAR);
    wr_train = exec_go && (r_op == OP_BRANCH);
    wr_btb   = exec_go && ((r_op == OP_JUMP) || ((r_op == OP_BRANCH) && r_taken));
    lht_wa   = clearing ? clr[LI_W-1:0] : li;
    lht_wd   = clearing ? '0 : lh_shift[LHB-1:0];
    lctr_wa  = clearing ? clr[LHB-1:0] : lht_q;
    lctr_wd  = clearing ? '0 : lctr_new;
    g_wa     = clearing ? clr[GI_W-1:0] : gi;
    gctr_wd  = clearing ? '0 : gctr_new;
    chs_wd   = clearing ? '0 : chs_new;
    b_wa     = clearing ? clr[BI_W-1:0] : bi;
    bval_wd  = !clearing;
    bkind_wd = '0;
    if (r_op == OP_JUMP) begin
      bkind_wd[KIND_UNCOND_BIT] = 1'b1;
      bkind_wd[KIND_CALL_BIT]   = r_call;
      bkind_wd[KIND_RET_BIT]    = r_ret;
    end
  end

  // Local history table.
  always_ff @(posedge clk) begin
    if (clearing || wr_train) lht_mem[lht_wa] <= lht_wd;
    if (state == ST_READ) lht_q <= lht_mem[li];
  end

  // Local counters, read with the local history returned above.
  always_ff @(posedge clk) begin
    if (clearing || wr_train) lctr_mem[lctr_wa] <= lctr_wd;
    if (state == ST_LOCAL) lctr_q <= lctr_mem[lht_q];
  end

  // Global counters and chooser.
  always_ff @(posedge clk) begin
    if (clearing || wr_train) begin
      gctr_mem[g_wa] <= gctr_wd;
      chs_mem[g_wa]  <= chs_wd;
    end
    if (state == ST_READ) begin
      gctr_q <= gctr_mem[gi];
      chs_q  <= chs_mem[gi];
    end
  end

  // Branch target buffer.
  always_ff @(posedge clk) begin
    if (clearing || wr_btb) bval_mem[b_wa] <= bval_wd;
    if (wr_btb) begin
      btag_mem[b_wa]  <= r_pc;
      btgt_mem[b_wa]  <= r_target;
      bkind_mem[b_wa] <= bkind_wd;
    end
    if (state == ST_READ) begin
      bval_q  <= bval_mem[bi];
      btag_q  <= btag_mem[bi];
      btgt_q  <= btgt_mem[bi];
      bkind_q <= bkind_mem[bi];
    end
  end

  // Global history and return stack pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      ghist <= '0;
      rtop  <= '0;
    end else if (exec_go) begin
      if (r_op == OP_RESTORE) begin
        ghist <= GHB'(r_ghr);
        rtop  <= r_depth;
      end else if ((r_op == OP_FETCH) && hit) begin
        ghist <= gh_shift[GHB-1:0];
        if (is_ret) begin
          if (rtop_nz && (top_rep <= DEPTH_W'(1))) rtop <= rtop_m1;
        end else if (is_call) begin
          if (!(rtop_nz && (top_addr == pc4))) rtop <= rtop + 1'b1;
        end
      end
    end
  end

  // Return stack entries.
  always_ff @(posedge clk) begin
    if (exec_go && (r_op == OP_FETCH) && hit) begin
      if (is_ret) begin
        if (rtop_nz && (top_rep > DEPTH_W'(1))) ras_rep[tslot] <= top_rep - 1'b1;
      end else if (is_call) begin
        if (rtop_nz && (top_addr == pc4)) begin
          ras_rep[tslot] <= top_rep + 1'b1;
        end else begin
          ras_addr[pslot] <= pc4;
          ras_rep[pslot]  <= DEPTH_W'(1);
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      if (r_op == OP_FETCH) begin
        pred_taken    <= ptaken;
        predicted_pc  <= next_pc;
        btb_hit       <= hit;
        unconditional <= unc;
        hit_is_call   <= is_call;
        hit_is_ret    <= is_ret;
      end else begin
        pred_taken    <= 1'b0;
        predicted_pc  <= '0;
        btb_hit       <= 1'b0;
        unconditional <= 1'b0;
        hit_is_call   <= 1'b0;
        hit_is_ret    <= 1'b0;
      end
    end
  end

endmodule

/* sv/tbp_checker.sv */
module tbp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        pred_taken,
  input logic [tbp_pkg::ADDR_W-1:0]  predicted_pc,
  input logic                        btb_hit,
  input logic                        unconditional,
  input logic                        hit_is_call,
  input logic                        hit_is_ret
);
  import tbp_pkg::*;

  // A stalled result transaction holds its address.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(predicted_pc))
    else $error("result changed while stalled");

  // Without a BTB hit nothing is predicted taken.
  a_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && !btb_hit |-> !pred_taken && !unconditional)
    else $error("taken prediction without a BTB hit");

  // Unconditional entries are always taken.
  a_unc: assert property (@(posedge clk) disable iff (rst)
    out_valid && unconditional |-> pred_taken && btb_hit)
    else $error("unconditional entry not taken");

  // Calls and returns are only ever stored as unconditional jumps.
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && (hit_is_call || hit_is_ret) |-> unconditional)
    else $error("call or return entry without unconditional flag");

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .pred_taken(pred_taken), .predicted_pc(predicted_pc), .btb_hit(btb_hit),
  .unconditional(unconditional), .hit_is_call(hit_is_call), .hit_is_ret(hit_is_ret)
);
